// File: src/multilevel_feedback_scheduler_defines.svh
// Assertion macros shared by the scheduler checkers.
`ifndef MULTILEVEL_FEEDBACK_SCHEDULER_DEFINES_SVH
`define MULTILEVEL_FEEDBACK_SCHEDULER_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define MFS_ASSERT_NOW(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define MFS_ASSERT_NEXT(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

`endif

// File: src/mfs_pkg.sv
// Types, codes and helper functions of the multilevel feedback scheduler.
package mfs_pkg;

   localparam int NUM_PROCS_DEF  = 64;
   localparam int NUM_LEVELS_DEF = 8;

   localparam int PID_W      = 6;
   localparam int PRIO_W     = 7;
   localparam int LVL_W      = 3;
   localparam int TIME_W     = 10;
   localparam int IO_W       = 3;
   localparam int Q_W        = 8;
   localparam int TICK_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [2:0] FUNC_ENQUEUE = 3'd0;
   localparam logic [2:0] FUNC_DEQUEUE = 3'd1;
   localparam logic [2:0] FUNC_TICK    = 3'd2;
   localparam logic [2:0] FUNC_YIELD   = 3'd3;
   localparam logic [2:0] FUNC_PREEMPT = 3'd4;
   localparam logic [2:0] FUNC_IO_DONE = 3'd5;

   localparam logic [1:0] STATUS_DONE     = 2'd0;
   localparam logic [1:0] STATUS_IGNORED  = 2'd1;
   localparam logic [1:0] STATUS_NO_BONUS = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_QUANTA_LOW     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTA_HIGH    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BOOST_INTERVAL = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BOOST_ENABLE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IO_BONUS_EN    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_IO_BONUS_LVLS  = 3'd5;

   localparam logic [31:0] QUANTA_LOW_RST  = 32'd268960770;
   localparam logic [31:0] QUANTA_HIGH_RST = 32'd4286595104;
   localparam logic [15:0] BOOST_INT_RST   = 16'd1000;

   localparam logic [PRIO_W-1:0] PRIO_HIGH = 7'd75;
   localparam logic [PRIO_W-1:0] PRIO_MID  = 7'd50;
   localparam logic [PRIO_W-1:0] PRIO_LOW  = 7'd25;

   localparam logic [IO_W-1:0]   IO_MAX           = 3'd7;
   localparam logic [IO_W-1:0]   YIELD_PROMOTE_IO = 3'd5;
   localparam logic [IO_W-1:0]   IODONE_PROMOTE   = 3'd3;
   localparam logic [TIME_W-1:0] TIME_MAX         = 10'd1023;
   localparam logic [TICK_W-1:0] TICK_MAX         = 16'hFFFF;

   typedef struct packed {
      logic [LVL_W-1:0]  lvl;
      logic [TIME_W-1:0] used;
      logic [IO_W-1:0]   io;
   } rec_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_EVAL,
      S_UNLINK,
      S_APPEND,
      S_LINK,
      S_TICKB,
      S_BOOST,
      S_SCHED,
      S_LVL,
      S_OUT
   } state_type;

   function automatic logic [Q_W-1:0] quantum_of(input logic [31:0] lo,
                                                 input logic [31:0] hi,
                                                 input logic [LVL_W-1:0] lvl);
      logic [31:0] w;
      w = lvl[2] ? hi : lo;
      return Q_W'(w >> {lvl[1:0], 3'b000});
   endfunction

   function automatic logic [LVL_W-1:0] level_for_prio(input logic [PRIO_W-1:0] prio);
      logic [LVL_W-1:0] l;
      if (prio >= PRIO_HIGH) l = 3'd0;
      else if (prio >= PRIO_MID) l = 3'd2;
      else if (prio >= PRIO_LOW) l = 3'd4;
      else l = 3'd6;
      return l;
   endfunction

endpackage

// File: src/multilevel_feedback_scheduler.sv
// Multilevel feedback scheduler: linked per-level FIFOs walked by one sequencer.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | req_func, req_pid, req_priority_req
//   rsp     | out       | rsp_valid/rsp_ready  | pick, switched, resched, boosted, level, status
//   csr     | in        | csr_valid/csr_ready  | csr_index, csr_data (always ready)
//
// One item at a time: req_ready is high only while the sequencer idles.
// Each move (read, unlink, append, tail link) passes through the link memories,
// which have one read and one write port each; a boosting tick moves the entries
// of levels 1 and up to level 0 one at a time, head first.
// Reset (synchronous, active high) empties all levels at once; no clearing pass.
// The result register lets the next item enter while a result waits on rsp_ready.
module multilevel_feedback_scheduler
   import mfs_pkg::*;
#(
   parameter int NUM_PROCS  = NUM_PROCS_DEF,
   parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [2:0]             req_func,
   input  logic [PID_W-1:0]       req_pid,
   input  logic [PRIO_W-1:0]      req_priority_req,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [6:0]      rsp_pick_pid,
   output logic                   rsp_switched,
   output logic                   rsp_resched,
   output logic                   rsp_boosted,
   output logic signed [3:0]      rsp_pid_level,
   output logic [1:0]             rsp_status,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int PW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
   localparam int KW = $clog2(NUM_PROCS + 1);
   localparam logic [KW-1:0] NIL = KW'(NUM_PROCS);

   // configuration
   logic [31:0]       quanta_lo_ff, quanta_hi_ff;
   logic [15:0]       binterval_ff;
   logic              benable_ff, ioen_ff;
   logic [2:0]        iolevels_ff;

   // sequencer and item context
   state_type         state_ff, state_in;
   logic [2:0]        func_ff, func_in;
   logic [PID_W-1:0]  pid_ff, pid_in;
   logic [PRIO_W-1:0] prio_ff, prio_in;
   logic [PW-1:0]     p_ff, p_in;
   logic [PW-1:0]     t_ff, t_in;
   rec_type           nrec_ff, nrec_in;
   logic              boosting_ff, boosting_in;
   logic              lvl_ok_ff, lvl_ok_in;
   logic [1:0]        status_ff, status_in;
   logic              sw_ff, sw_in, rs_ff, rs_in, bo_ff, bo_in;

   // scheduler state
   logic [PID_W-1:0]  running_ff, running_in;
   logic              tracked_ff, tracked_in;
   logic [TICK_W-1:0] slice_ff, slice_in;
   logic [TICK_W-1:0] bticks_ff, bticks_in;
   logic [KW-1:0]     head_ff [NUM_LEVELS];
   logic [KW-1:0]     head_in [NUM_LEVELS];
   logic [KW-1:0]     tail_ff [NUM_LEVELS];
   logic [KW-1:0]     tail_in [NUM_LEVELS];
   logic [NUM_PROCS-1:0] valid_ff, valid_in;

   // entry memories
   rec_type           rec_mem  [NUM_PROCS];
   logic [KW-1:0]     next_mem [NUM_PROCS];
   logic [KW-1:0]     prev_mem [NUM_PROCS];
   rec_type           rd_rec_ff;
   logic [KW-1:0]     rd_next_ff, rd_prev_ff;
   logic              rd_en;
   logic [PW-1:0]     rd_addr;
   logic              rec_we, nxt_we, prv_we;
   logic [PW-1:0]     rec_wa, nxt_wa, prv_wa;
   rec_type           rec_wd;
   logic [KW-1:0]     nxt_wd, prv_wd;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic signed [6:0] rsp_pick_ff, rsp_pick_in;
   logic              rsp_sw_ff, rsp_sw_in, rsp_rs_ff, rsp_rs_in, rsp_bo_ff, rsp_bo_in;
   logic signed [3:0] rsp_lvl_ff, rsp_lvl_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;

   // shared arithmetic on the entry just read
   logic [Q_W-1:0]    quantum;
   logic [TIME_W:0]   used_sum;
   logic [TIME_W-1:0] used_sat;
   logic [IO_W-1:0]   io_inc;
   logic [LVL_W-1:0]  bonus_lvl;
   logic [TICK_W:0]   bticks_inc;

   // head pick and boost scan
   logic              pick_found, boost_found;
   logic [KW-1:0]     pick_ptr, boost_ptr;

   logic              pid_ok, present, run_ok, run_live;
   logic [PW-1:0]     pidx, ridx;
   state_type         after_move;

   assign req_ready     = (state_ff == S_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pick_pid  = rsp_pick_ff;
   assign rsp_switched  = rsp_sw_ff;
   assign rsp_resched   = rsp_rs_ff;
   assign rsp_boosted   = rsp_bo_ff;
   assign rsp_pid_level = rsp_lvl_ff;
   assign rsp_status    = rsp_status_ff;

   assign pidx     = PW'(pid_ff);
   assign ridx     = PW'(running_ff);
   assign pid_ok   = int'(pid_ff) < NUM_PROCS;
   assign run_ok   = int'(running_ff) < NUM_PROCS;
   assign present  = pid_ok && valid_ff[pidx];
   assign run_live = tracked_ff && run_ok && valid_ff[ridx];

   assign quantum    = quantum_of(quanta_lo_ff, quanta_hi_ff, rd_rec_ff.lvl);
   assign used_sum   = {1'b0, rd_rec_ff.used} + (TIME_W + 1)'(quantum);
   assign used_sat   = (used_sum > {1'b0, TIME_MAX}) ? TIME_MAX : used_sum[TIME_W-1:0];
   assign io_inc     = (rd_rec_ff.io == IO_MAX) ? IO_MAX : rd_rec_ff.io + 3'd1;
   assign bonus_lvl  = (rd_rec_ff.lvl > iolevels_ff) ? rd_rec_ff.lvl - iolevels_ff : 3'd0;
   assign bticks_inc = {1'b0, bticks_ff} + 17'd1;

   // Lowest non-empty level wins; the boost scan skips level 0.
   always_comb begin
      pick_found  = 1'b0;
      pick_ptr    = NIL;
      boost_found = 1'b0;
      boost_ptr   = NIL;
      for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
         if (head_ff[l] != NIL) begin
            pick_found = 1'b1;
            pick_ptr   = head_ff[l];
            if (l > 0) begin
               boost_found = 1'b1;
               boost_ptr   = head_ff[l];
            end
         end
      end
   end

   // Where a finished move goes next.
   always_comb begin
      if (boosting_ff) after_move = S_BOOST;
      else if (func_ff == FUNC_YIELD || func_ff == FUNC_PREEMPT) after_move = S_SCHED;
      else after_move = S_LVL;
   end

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      pid_in        = pid_ff;
      prio_in       = prio_ff;
      p_in          = p_ff;
      t_in          = t_ff;
      nrec_in       = nrec_ff;
      boosting_in   = boosting_ff;
      lvl_ok_in     = lvl_ok_ff;
      status_in     = status_ff;
      sw_in         = sw_ff;
      rs_in         = rs_ff;
      bo_in         = bo_ff;
      running_in    = running_ff;
      tracked_in    = tracked_ff;
      slice_in      = slice_ff;
      bticks_in     = bticks_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      valid_in      = valid_ff;
      rd_en         = 1'b0;
      rd_addr       = p_ff;
      rec_we        = 1'b0;
      rec_wa        = p_ff;
      rec_wd        = nrec_ff;
      nxt_we        = 1'b0;
      nxt_wa        = p_ff;
      nxt_wd        = NIL;
      prv_we        = 1'b0;
      prv_wa        = p_ff;
      prv_wd        = NIL;
      rsp_valid_in  = rsp_valid_ff;
      rsp_pick_in   = rsp_pick_ff;
      rsp_sw_in     = rsp_sw_ff;
      rsp_rs_in     = rsp_rs_ff;
      rsp_bo_in     = rsp_bo_ff;
      rsp_lvl_in    = rsp_lvl_ff;
      rsp_status_in = rsp_status_ff;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               func_in     = req_func;
               pid_in      = req_pid;
               prio_in     = req_priority_req;
               p_in        = PW'(req_pid);
               boosting_in = 1'b0;
               status_in   = STATUS_DONE;
               sw_in       = 1'b0;
               rs_in       = 1'b0;
               bo_in       = 1'b0;
               state_in    = S_START;
            end
         end

         S_START: begin
            case (func_ff)
               FUNC_ENQUEUE: begin
                  if (present || !pid_ok) begin
                     status_in = STATUS_IGNORED;
                     state_in  = S_LVL;
                  end else begin
                     valid_in[pidx] = 1'b1;
                     nrec_in        = '{lvl: level_for_prio(prio_ff), used: '0, io: '0};
                     state_in       = S_APPEND;
                  end
               end
               FUNC_DEQUEUE: begin
                  if (!present) begin
                     status_in = STATUS_IGNORED;
                     state_in  = S_LVL;
                  end else begin
                     if (tracked_ff && running_ff == pid_ff) tracked_in = 1'b0;
                     rd_en    = 1'b1;
                     state_in = S_EVAL;
                  end
               end
               FUNC_TICK: begin
                  if (slice_ff != TICK_MAX) slice_in = slice_ff + 16'd1;
                  if (run_live) begin
                     rd_en    = 1'b1;
                     rd_addr  = ridx;
                     state_in = S_EVAL;
                  end else begin
                     state_in = S_TICKB;
                  end
               end
               FUNC_YIELD, FUNC_PREEMPT: begin
                  if (run_live) begin
                     p_in     = ridx;
                     rd_en    = 1'b1;
                     rd_addr  = ridx;
                     state_in = S_EVAL;
                  end else begin
                     state_in = S_SCHED;
                  end
               end
               FUNC_IO_DONE: begin
                  if (!ioen_ff) begin
                     status_in = STATUS_NO_BONUS;
                     state_in  = S_LVL;
                  end else if (!present) begin
                     status_in = STATUS_IGNORED;
                     state_in  = S_LVL;
                  end else begin
                     rd_en    = 1'b1;
                     state_in = S_EVAL;
                  end
               end
               default: begin
                  status_in = STATUS_IGNORED;
                  state_in  = S_LVL;
               end
            endcase
         end

         // Entry record and links of p (of the running entry on a tick) are in the read registers now.
         S_EVAL: begin
            rec_wd = rd_rec_ff;
            if (boosting_ff) begin
               nrec_in  = '{lvl: '0, used: '0, io: rd_rec_ff.io};
               state_in = S_UNLINK;
            end else begin
               case (func_ff)
                  FUNC_DEQUEUE: state_in = S_UNLINK;
                  FUNC_TICK: begin
                     rs_in    = slice_ff >= TICK_W'(quantum);
                     state_in = S_TICKB;
                  end
                  FUNC_YIELD: begin
                     if (ioen_ff && io_inc > YIELD_PROMOTE_IO) begin
                        if (rd_rec_ff.lvl != 3'd0) begin
                           nrec_in  = '{lvl: rd_rec_ff.lvl - 3'd1, used: '0, io: '0};
                           state_in = S_UNLINK;
                        end else begin
                           rec_we   = 1'b1;
                           rec_wd   = '{lvl: rd_rec_ff.lvl, used: '0, io: '0};
                           state_in = S_SCHED;
                        end
                     end else begin
                        rec_we   = 1'b1;
                        rec_wd   = '{lvl: rd_rec_ff.lvl, used: '0, io: io_inc};
                        state_in = S_SCHED;
                     end
                  end
                  FUNC_PREEMPT: begin
                     if (used_sat >= {1'b0, quantum, 1'b0}) begin
                        if (int'(rd_rec_ff.lvl) >= NUM_LEVELS - 1) begin
                           // top level: stay in place, start the charge over
                           rec_we   = 1'b1;
                           rec_wd   = '{lvl: rd_rec_ff.lvl, used: '0, io: rd_rec_ff.io};
                           state_in = S_SCHED;
                        end else begin
                           nrec_in  = '{lvl: rd_rec_ff.lvl + 3'd1, used: '0,
                                        io: rd_rec_ff.io};
                           state_in = S_UNLINK;
                        end
                     end else begin
                        // requeue at the tail of its own level
                        nrec_in  = '{lvl: rd_rec_ff.lvl, used: used_sat, io: rd_rec_ff.io};
                        state_in = S_UNLINK;
                     end
                  end
                  FUNC_IO_DONE: begin
                     if (io_inc > IODONE_PROMOTE && rd_rec_ff.lvl != 3'd0) begin
                        if (iolevels_ff != 3'd0) begin
                           nrec_in  = '{lvl: bonus_lvl, used: '0, io: '0};
                           state_in = S_UNLINK;
                        end else begin
                           rec_we   = 1'b1;
                           rec_wd   = '{lvl: rd_rec_ff.lvl, used: rd_rec_ff.used, io: '0};
                           state_in = S_LVL;
                        end
                     end else begin
                        rec_we   = 1'b1;
                        rec_wd   = '{lvl: rd_rec_ff.lvl, used: rd_rec_ff.used, io: io_inc};
                        state_in = S_LVL;
                     end
                  end
                  default: state_in = S_LVL;
               endcase
            end
         end

         // Splice p out: the neighbors point past it, or head and tail move.
         S_UNLINK: begin
            if (rd_prev_ff != NIL) begin
               nxt_we = 1'b1;
               nxt_wa = PW'(rd_prev_ff);
               nxt_wd = rd_next_ff;
            end else begin
               head_in[rd_rec_ff.lvl] = rd_next_ff;
            end
            if (rd_next_ff != NIL) begin
               prv_we = 1'b1;
               prv_wa = PW'(rd_next_ff);
               prv_wd = rd_prev_ff;
            end else begin
               tail_in[rd_rec_ff.lvl] = rd_prev_ff;
            end
            if (func_ff == FUNC_DEQUEUE && !boosting_ff) begin
               valid_in[p_ff] = 1'b0;
               state_in       = S_LVL;
            end else begin
               state_in = S_APPEND;
            end
         end

         // Hang p on the tail of its new level.
         S_APPEND: begin
            rec_we = 1'b1;
            rec_wd = nrec_ff;
            nxt_we = 1'b1;
            nxt_wd = NIL;
            prv_we = 1'b1;
            prv_wd = tail_ff[nrec_ff.lvl];
            tail_in[nrec_ff.lvl] = KW'(p_ff);
            if (tail_ff[nrec_ff.lvl] == NIL) begin
               head_in[nrec_ff.lvl] = KW'(p_ff);
               state_in = after_move;
            end else begin
               t_in     = PW'(tail_ff[nrec_ff.lvl]);
               state_in = S_LINK;
            end
         end

         S_LINK: begin
            nxt_we   = 1'b1;
            nxt_wa   = t_ff;
            nxt_wd   = KW'(p_ff);
            state_in = after_move;
         end

         S_TICKB: begin
            state_in = S_LVL;
            if (benable_ff) begin
               if (bticks_inc >= {1'b0, binterval_ff}) begin
                  bticks_in   = '0;
                  bo_in       = 1'b1;
                  boosting_in = 1'b1;
                  state_in    = S_BOOST;
               end else begin
                  bticks_in = bticks_inc[TICK_W-1:0];
               end
            end
         end

         // Drain levels 1 and up into level 0, head first.
         S_BOOST: begin
            if (boost_found) begin
               p_in     = PW'(boost_ptr);
               rd_en    = 1'b1;
               rd_addr  = PW'(boost_ptr);
               state_in = S_EVAL;
            end else begin
               boosting_in = 1'b0;
               state_in    = S_LVL;
            end
         end

         S_SCHED: begin
            tracked_in = 1'b0;
            if (pick_found) begin
               sw_in      = PID_W'(pick_ptr) != running_ff;
               running_in = PID_W'(pick_ptr);
               tracked_in = 1'b1;
               slice_in   = '0;
            end
            state_in = S_LVL;
         end

         S_LVL: begin
            lvl_ok_in = present;
            rd_en     = 1'b1;
            rd_addr   = pidx;
            state_in  = S_OUT;
         end

         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_pick_in   = pick_found ? 7'(pick_ptr) : -7'sd1;
               rsp_sw_in     = sw_ff;
               rsp_rs_in     = rs_ff;
               rsp_bo_in     = bo_ff;
               rsp_lvl_in    = lvl_ok_ff ? $signed({1'b0, rd_rec_ff.lvl}) : -4'sd1;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // Memories: one registered read and one write port each.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_rec_ff  <= rec_mem[rd_addr];
         rd_next_ff <= next_mem[rd_addr];
         rd_prev_ff <= prev_mem[rd_addr];
      end
      if (rec_we) rec_mem[rec_wa] <= rec_wd;
      if (nxt_we) next_mem[nxt_wa] <= nxt_wd;
      if (prv_we) prev_mem[prv_wa] <= prv_wd;
   end

   // Item context and payload registers hold without reset.
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      pid_ff        <= pid_in;
      prio_ff       <= prio_in;
      p_ff          <= p_in;
      t_ff          <= t_in;
      nrec_ff       <= nrec_in;
      lvl_ok_ff     <= lvl_ok_in;
      status_ff     <= status_in;
      sw_ff         <= sw_in;
      rs_ff         <= rs_in;
      bo_ff         <= bo_in;
      rsp_pick_ff   <= rsp_pick_in;
      rsp_sw_ff     <= rsp_sw_in;
      rsp_rs_ff     <= rsp_rs_in;
      rsp_bo_ff     <= rsp_bo_in;
      rsp_lvl_ff    <= rsp_lvl_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         boosting_ff  <= 1'b0;
         running_ff   <= '0;
         tracked_ff   <= 1'b0;
         slice_ff     <= '0;
         bticks_ff    <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int l = 0; l < NUM_LEVELS; l++) begin
            head_ff[l] <= NIL;
            tail_ff[l] <= NIL;
         end
      end else begin
         state_ff     <= state_in;
         boosting_ff  <= boosting_in;
         running_ff   <= running_in;
         tracked_ff   <= tracked_in;
         slice_ff     <= slice_in;
         bticks_ff    <= bticks_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
      end
   end

   // Configuration writes; an unknown index is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         quanta_lo_ff <= QUANTA_LOW_RST;
         quanta_hi_ff <= QUANTA_HIGH_RST;
         binterval_ff <= BOOST_INT_RST;
         benable_ff   <= 1'b1;
         ioen_ff      <= 1'b1;
         iolevels_ff  <= 3'd1;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_QUANTA_LOW:     quanta_lo_ff <= csr_data;
            CSR_QUANTA_HIGH:    quanta_hi_ff <= csr_data;
            CSR_BOOST_INTERVAL: binterval_ff <= csr_data[15:0];
            CSR_BOOST_ENABLE:   benable_ff   <= csr_data[0];
            CSR_IO_BONUS_EN:    ioen_ff      <= csr_data[0];
            CSR_IO_BONUS_LVLS:  iolevels_ff  <= csr_data[2:0];
            default: ;
         endcase
      end
   end

endmodule

// File: src/mfs_checker.sv
// Port-level checker for the multilevel feedback scheduler, bound to the top level.
`include "multilevel_feedback_scheduler_defines.svh"

module mfs_checker
   import mfs_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic signed [6:0] rsp_pick_pid,
   input logic              rsp_switched,
   input logic              rsp_resched,
   input logic              rsp_boosted,
   input logic signed [3:0] rsp_pid_level,
   input logic [1:0]        rsp_status
);

   `MFS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_pick_pid), "stalled result dropped or changed")
   `MFS_ASSERT_NOW(a_tick_flags, rsp_valid && (rsp_resched || rsp_boosted), rsp_status == STATUS_DONE && !rsp_switched, "tick flags mixed with other results")
   `MFS_ASSERT_NOW(a_level_range, rsp_valid, !rsp_pid_level[3] || rsp_pid_level == -4'sd1, "level below minus one")
   `MFS_ASSERT_NOW(a_pick_range, rsp_valid, !rsp_pick_pid[6] || rsp_pick_pid == -7'sd1, "pick below minus one")

endmodule

bind multilevel_feedback_scheduler mfs_checker u_mfs_checker (.*);
